// ===== sv/co2m_pkg.sv =====
// Shared types and constants for the CO2 level hysteresis monitor.
package co2m_pkg;

    typedef logic [1:0] t_level;

    localparam t_level LVL_OK   = 2'd0;
    localparam t_level LVL_WARN = 2'd1;
    localparam t_level LVL_ERR  = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_HIGH_THR = 2'd0;
    localparam t_cfg_idx CFG_MID_THR  = 2'd1;
    localparam t_cfg_idx CFG_LOW_THR  = 2'd2;
    localparam t_cfg_idx CFG_QUALIFY  = 2'd3;

    localparam logic [15:0] RST_HIGH_THR = 16'd1000;
    localparam logic [15:0] RST_MID_THR  = 16'd850;
    localparam logic [15:0] RST_LOW_THR  = 16'd750;
    localparam logic [7:0]  RST_QUALIFY  = 8'd10;
    localparam logic [7:0]  RST_DOWN_CNT = 8'd10;

    // Frame positions of the concentration bytes.
    localparam int POS_HIGH_BYTE = 2;
    localparam int POS_LOW_BYTE  = 3;

    typedef struct packed {
        logic [15:0] high_thr;
        logic [15:0] mid_thr;
        logic [15:0] low_thr;
        logic [7:0]  qualify;
    } t_cfg;

    typedef struct packed {
        logic [15:0] ppm;
        logic        level_changed;
        t_level      new_level;
        logic        rising;
    } t_result;

endpackage

// ===== sv/co2m_byte_if.sv =====
// Request channel that carries one received sensor byte.
interface co2m_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== sv/co2m_result_if.sv =====
// Request channel that carries one per-frame concentration and alarm result.
interface co2m_result_if;
    logic              valid;
    logic              ready;
    logic [15:0]       ppm;
    logic              level_changed;
    co2m_pkg::t_level  new_level;
    logic              rising;

    modport source (output valid, output ppm, output level_changed,
                    output new_level, output rising, input ready);
    modport sink   (input valid, input ppm, input level_changed,
                    input new_level, input rising, output ready);
endinterface

// ===== sv/co2m_frame.sv =====
// Frame assembler: counts bytes and registers the concentration of each frame.
module co2m_frame #(
    parameter int FRAME_BYTES = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_acc,
    input  logic [7:0]  i_byte,
    input  logic        i_take,
    output logic        o_valid,
    output logic [15:0] o_ppm
);

    localparam int                CNT_W = $clog2(FRAME_BYTES);
    localparam logic [CNT_W-1:0]  LAST  = CNT_W'(FRAME_BYTES - 1);
    localparam logic [CNT_W-1:0]  P_HI  = CNT_W'(co2m_pkg::POS_HIGH_BYTE);
    localparam logic [CNT_W-1:0]  P_LO  = CNT_W'(co2m_pkg::POS_LOW_BYTE);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]       r_hi, n_hi;
    logic [7:0]       r_lo, n_lo;
    logic             r_vld, n_vld;
    logic [15:0]      r_ppm, n_ppm;
    logic             last;

    assign last = (r_cnt == LAST);

    always_comb begin
        n_cnt = r_cnt;
        n_hi  = r_hi;
        n_lo  = r_lo;
        n_vld = r_vld;
        n_ppm = r_ppm;
        if (i_take) begin
            n_vld = 1'b0;
        end
        if (i_acc) begin
            if (r_cnt == P_HI) begin
                n_hi = i_byte;
            end
            if (r_cnt == P_LO) begin
                n_lo = i_byte;
            end
            if (last) begin
                n_cnt = '0;
                n_vld = 1'b1;
                // The low byte may be the last byte of a short frame.
                n_ppm = {r_hi, n_lo};
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_vld <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_vld <= n_vld;
        end
        r_hi  <= n_hi;
        r_lo  <= n_lo;
        r_ppm <= n_ppm;
    end

    assign o_valid = r_vld;
    assign o_ppm   = r_ppm;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= LAST)
        else $error("frame byte counter left its range");
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && last) |=> (r_vld && r_cnt == '0))
        else $error("frame end did not raise a request");
`endif

endmodule

// ===== sv/co2m_alarm.sv =====
// Alarm level tracker with qualifying counters and the result register.
module co2m_alarm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  co2m_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    input  logic [15:0]         i_ppm,
    output logic                o_ready,
    output logic                o_valid,
    output co2m_pkg::t_result   o_res,
    input  logic                i_ready
);

    co2m_pkg::t_level  r_lvl, n_lvl;
    logic [7:0]        r_up, n_up;
    logic [7:0]        r_dn, n_dn;
    logic              r_ovld, n_ovld;
    co2m_pkg::t_result r_res, n_res;

    logic       take;
    logic       band_hi, band_mid, band_lo;
    logic       up_inc, dn_inc, up_hit, dn_hit, changed;
    logic [7:0] up_next, dn_next;
    co2m_pkg::t_level target;

    assign o_ready = !r_ovld || i_ready;
    assign take    = i_valid && o_ready;

    always_comb begin
        band_hi  = i_ppm > i_cfg.high_thr;
        band_mid = !band_hi && (i_ppm > i_cfg.mid_thr);
        band_lo  = !band_hi && !band_mid && (i_ppm < i_cfg.low_thr);

        up_inc = (band_hi && r_lvl != co2m_pkg::LVL_ERR)
              || (band_mid && r_lvl == co2m_pkg::LVL_OK);
        dn_inc = (band_mid && r_lvl == co2m_pkg::LVL_ERR)
              || (band_lo && r_lvl == co2m_pkg::LVL_WARN);

        // A counter already at or past the qualify count stays put.
        up_inc  = up_inc && (r_up < i_cfg.qualify);
        dn_inc  = dn_inc && (r_dn < i_cfg.qualify);
        up_next = r_up + 8'd1;
        dn_next = r_dn + 8'd1;
        up_hit  = up_inc && (up_next == i_cfg.qualify);
        dn_hit  = dn_inc && (dn_next == i_cfg.qualify);
        changed = up_hit || dn_hit;

        priority if (band_hi) begin
            target = co2m_pkg::LVL_ERR;
        end else if (band_mid) begin
            target = co2m_pkg::LVL_WARN;
        end else begin
            target = co2m_pkg::LVL_OK;
        end

        n_lvl  = r_lvl;
        n_up   = r_up;
        n_dn   = r_dn;
        n_res  = r_res;
        n_ovld = r_ovld && !i_ready;
        if (take) begin
            n_ovld = 1'b1;
            if (changed) begin
                n_lvl = target;
                n_up  = '0;
                n_dn  = '0;
            end else begin
                if (up_inc) begin
                    n_up = up_next;
                end
                if (dn_inc) begin
                    n_dn = dn_next;
                end
            end
            n_res.ppm           = i_ppm;
            n_res.level_changed = changed;
            n_res.new_level     = changed ? target : r_lvl;
            n_res.rising        = up_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl  <= co2m_pkg::LVL_OK;
            r_up   <= '0;
            r_dn   <= co2m_pkg::RST_DOWN_CNT;
            r_ovld <= 1'b0;
        end else begin
            r_lvl  <= n_lvl;
            r_up   <= n_up;
            r_dn   <= n_dn;
            r_ovld <= n_ovld;
        end
        r_res <= n_res;
    end

    assign o_valid = r_ovld;
    assign o_res   = r_res;

`ifndef SYNTHESIS
    a_lvl_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lvl <= co2m_pkg::LVL_ERR)
        else $error("alarm level holds an unused code");
    a_change_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && changed) |=> (r_up == '0 && r_dn == '0 && r_lvl == r_res.new_level))
        else $error("level change did not clear the counters");
    a_rise_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && r_res.rising) |-> r_res.level_changed)
        else $error("rising flag without a level change");
`endif

endmodule

// ===== sv/co2_level_hysteresis_monitor.sv =====
// Top level of the CO2 level hysteresis monitor: config registers and the two stages.
//
// Usage: the i_rx channel takes one byte from the sensor serial link per request.
// Every FRAME_BYTES bytes make one frame; no start byte or checksum is checked.
// Bytes 2 and 3 of each frame form ppm = byte2 * 256 + byte3.
// For each frame the o_res channel delivers one request: the ppm, the alarm
// level after the frame (0 ok, 1 warning, 2 error), and, when the level moved,
// level_changed together with the direction in rising.
// The level moves only after qualify_count qualifying frames, which need not be
// consecutive; frames outside a band leave the up and down counters untouched.
// Throughput is one byte per cycle while i_rx.ready is high. The result of a
// frame passes from its last byte to the frame register and then to the result
// register. When the receiver stalls, the result register holds its request and
// the frame register can still hold one more frame; only when both are full is
// i_rx.ready dropped. Reset (i_rst_n low at a clock edge) restores the default
// thresholds and qualify count, clears the byte position, sets the level to ok,
// the up counter to zero and the down counter to ten. The config port writes
// one register per cycle at i_cfg_we. The user must write only while idle; the
// block itself does not enforce it.
module co2_level_hysteresis_monitor #(
    parameter int FRAME_BYTES = 9
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [co2m_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [co2m_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    co2m_byte_if.sink                         i_rx,
    co2m_result_if.source                     o_res
);

    co2m_pkg::t_cfg    r_cfg, n_cfg;
    co2m_pkg::t_result res;
    logic              frm_valid;
    logic [15:0]       frm_ppm;
    logic              alm_ready;
    logic              rx_acc;
    logic              frm_take;

    // Configuration registers; every index of the port maps to a register.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                co2m_pkg::CFG_HIGH_THR: n_cfg.high_thr = i_cfg_wdata;
                co2m_pkg::CFG_MID_THR:  n_cfg.mid_thr  = i_cfg_wdata;
                co2m_pkg::CFG_LOW_THR:  n_cfg.low_thr  = i_cfg_wdata;
                co2m_pkg::CFG_QUALIFY:  n_cfg.qualify  = i_cfg_wdata[7:0];
                default:                n_cfg          = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_thr <= co2m_pkg::RST_HIGH_THR;
            r_cfg.mid_thr  <= co2m_pkg::RST_MID_THR;
            r_cfg.low_thr  <= co2m_pkg::RST_LOW_THR;
            r_cfg.qualify  <= co2m_pkg::RST_QUALIFY;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // A byte is taken whenever the frame register is empty or drains this cycle.
    assign i_rx.ready = !frm_valid || alm_ready;
    assign rx_acc     = i_rx.valid && i_rx.ready;
    assign frm_take   = frm_valid && alm_ready;

    co2m_frame #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (rx_acc),
        .i_byte  (i_rx.rx_byte),
        .i_take  (frm_take),
        .o_valid (frm_valid),
        .o_ppm   (frm_ppm)
    );

    co2m_alarm u_alarm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (frm_valid),
        .i_ppm   (frm_ppm),
        .o_ready (alm_ready),
        .o_valid (o_res.valid),
        .o_res   (res),
        .i_ready (o_res.ready)
    );

    assign o_res.ppm           = res.ppm;
    assign o_res.level_changed = res.level_changed;
    assign o_res.new_level     = res.new_level;
    assign o_res.rising        = res.rising;

endmodule

// ===== test/co2_level_hysteresis_monitor_tb.sv =====
// Self-checking testbench for the CO2 level hysteresis monitor with a frame-level predictor.
module co2_level_hysteresis_monitor_tb;
    import co2m_pkg::*;

    // The frame length used for the instance, and the number of clock edges we
    // allow past the last expected reading before touching the config port.
    // A frame's last byte passes the frame register and then the result register, so
    // the wait leaves room for anything still moving through the frame register.
    localparam int          FRAME_LEN     = 9;
    localparam int          SETTLE_CYCLES = 6;
    localparam int unsigned RUN_LIMIT     = 2_000_000;

    // Frame-level scoreboard. It keeps its own copy of the thresholds, the
    // frame position and the alarm counters, predicts the reading for every
    // completed frame, and matches readings from the block in order.
    class co2_reading_scoreboard;
        logic [15:0] high_thr;
        logic [15:0] mid_thr;
        logic [15:0] low_thr;
        logic [7:0]  qualify;
        int unsigned frame_pos;
        logic [7:0]  ppm_hi;
        logic [7:0]  ppm_lo;
        t_level      level;
        logic [7:0]  up_cnt;
        logic [7:0]  down_cnt;
        t_result     pending_readings[$];
        int unsigned mismatches;

        function new();
            high_thr   = RST_HIGH_THR;
            mid_thr    = RST_MID_THR;
            low_thr    = RST_LOW_THR;
            qualify    = RST_QUALIFY;
            frame_pos  = 0;
            ppm_hi     = '0;
            ppm_lo     = '0;
            level      = LVL_OK;
            up_cnt     = '0;
            down_cnt   = RST_DOWN_CNT;
            mismatches = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [15:0] value);
            case (idx)
                CFG_HIGH_THR: high_thr = value;
                CFG_MID_THR:  mid_thr  = value;
                CFG_LOW_THR:  low_thr  = value;
                CFG_QUALIFY:  qualify  = value[7:0];
                default: ;
            endcase
        endfunction

        // One more qualifying frame. A counter that already sits at or above
        // the qualify count stays put, so a lowered count freezes it.
        function bit count_qualifying(inout logic [7:0] ctr);
            if (ctr < qualify) begin
                ctr = ctr + 8'd1;
                return ctr == qualify;
            end
            return 1'b0;
        endfunction

        function void note_rx_byte(logic [7:0] rx_byte);
            logic [15:0] ppm;
            logic        changed;
            logic        rising;
            t_level      target;
            t_result     want;
            if (frame_pos == POS_HIGH_BYTE) ppm_hi = rx_byte;
            if (frame_pos == POS_LOW_BYTE) ppm_lo = rx_byte;
            if (frame_pos + 1 < FRAME_LEN) begin
                frame_pos++;
                return;
            end
            frame_pos = 0;
            ppm       = {ppm_hi, ppm_lo};
            changed   = 1'b0;
            rising    = 1'b0;
            target    = level;
            // The bands are tried high, then middle, then low, so with
            // unordered thresholds the first match wins.
            if (ppm > high_thr) begin
                if (level != LVL_ERR && count_qualifying(up_cnt)) begin
                    target  = LVL_ERR;
                    changed = 1'b1;
                    rising  = 1'b1;
                end
            end else if (ppm > mid_thr) begin
                if (level == LVL_OK) begin
                    if (count_qualifying(up_cnt)) begin
                        target  = LVL_WARN;
                        changed = 1'b1;
                        rising  = 1'b1;
                    end
                end else if (level == LVL_ERR) begin
                    if (count_qualifying(down_cnt)) begin
                        target  = LVL_WARN;
                        changed = 1'b1;
                    end
                end
            end else if (ppm < low_thr) begin
                if (level == LVL_WARN && count_qualifying(down_cnt)) begin
                    target  = LVL_OK;
                    changed = 1'b1;
                end
            end
            if (changed) begin
                level    = target;
                up_cnt   = '0;
                down_cnt = '0;
            end
            want = '{ppm: ppm, level_changed: changed, new_level: level, rising: rising};
            pending_readings.push_back(want);
        endfunction

        function void check_reading(t_result got);
            t_result want;
            if (pending_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reading: ppm=%0d chg=%0b lvl=%0d rise=%0b",
                             got.ppm, got.level_changed, got.new_level, got.rising);
                return;
            end
            want = pending_readings.pop_front();
            if (got.ppm !== want.ppm || got.level_changed !== want.level_changed ||
                got.new_level !== want.new_level || got.rising !== want.rising) begin
                mismatches++;
                // Fields in order: ppm, level_changed, new_level, rising.
                if (mismatches <= 10)
                    $display("reading mismatch: want %0d %0b %0d %0b, got %0d %0b %0d %0b",
                             want.ppm, want.level_changed, want.new_level, want.rising,
                             got.ppm, got.level_changed, got.new_level, got.rising);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    co2m_byte_if   rx_if ();
    co2m_result_if res_if ();

    co2_reading_scoreboard sb;
    t_result               seen_reading;
    int                    src_idle_pct;
    int                    sink_idle_pct;
    int unsigned           bytes_sent;
    int unsigned           tx_pos;
    int unsigned           setting_no;

    co2_level_hysteresis_monitor #(.FRAME_BYTES(FRAME_LEN)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx        (rx_if),
        .o_res       (res_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The run is bounded no matter what the block does. A hung handshake or a
    // missing reading ends up here.
    initial begin
        #RUN_LIMIT;
        $display("FAILURE");
        $finish;
    end

    // The receiver drops ready at random, at the rate set for the current phase.
    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Both channels are observed at the clock edge. A reading is checked before
    // the byte of the same edge is noted; a byte can never produce a reading at
    // the edge that accepts it, so the order only keeps the queue tidy.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                seen_reading = '{ppm: res_if.ppm, level_changed: res_if.level_changed,
                                 new_level: res_if.new_level, rising: res_if.rising};
                sb.check_reading(seen_reading);
            end
            if (rx_if.valid && rx_if.ready)
                sb.note_rx_byte(rx_if.rx_byte);
        end
    end

    // Offers one byte request, with random idle cycles in front of it, and
    // returns right after the edge that accepted it. Valid is left high so a
    // back-to-back byte does not need to lower it first.
    task automatic send_rx_byte(input logic [7:0] rx_byte);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            rx_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= rx_byte;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        bytes_sent++;
        tx_pos = (tx_pos + 1) % FRAME_LEN;
    endtask

    // Sends bytes up to the next frame boundary, with the concentration in the
    // two ppm positions and random filler everywhere else. After stray bytes
    // the first frame is only partly ours, which is exactly the point of them.
    task automatic send_frame(input logic [15:0] ppm);
        logic [7:0] rx_byte;
        do begin
            rx_byte = 8'($urandom);
            if (tx_pos == POS_HIGH_BYTE) rx_byte = ppm[15:8];
            if (tx_pos == POS_LOW_BYTE) rx_byte = ppm[7:0];
            send_rx_byte(rx_byte);
        end while (tx_pos != 0);
    endtask

    // Stops the sender and waits until every predicted reading has come back,
    // then lets the pipeline settle so that a partial frame is harmless.
    task automatic drain_readings();
        rx_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.write_reg(idx, value);
    endtask

    // Writes all four registers back to back. The qualify count only uses
    // the low byte of the write data, so the upper byte carries junk.
    task automatic program_monitor(input logic [15:0] high_thr, input logic [15:0] mid_thr,
                                   input logic [15:0] low_thr, input logic [7:0] qualify);
        put_reg(CFG_HIGH_THR, high_thr);
        put_reg(CFG_MID_THR, mid_thr);
        put_reg(CFG_LOW_THR, low_thr);
        put_reg(CFG_QUALIFY, {8'($urandom), qualify});
        i_cfg_we <= 1'b0;
    endtask

    // Picks a concentration inside a band: 0 high, 1 middle, 2 between low and
    // middle, 3 low. A quarter of the picks sit right on a band edge. An empty
    // band falls back to any value.
    function automatic logic [15:0] pick_ppm(input int band);
        int lo;
        int hi;
        lo = 0;
        hi = 65535;
        case (band)
            0: lo = int'(sb.high_thr) + 1;
            1: begin
                lo = int'(sb.mid_thr) + 1;
                hi = int'(sb.high_thr);
            end
            2: begin
                lo = int'(sb.low_thr);
                hi = int'(sb.mid_thr);
            end
            default: hi = int'(sb.low_thr) - 1;
        endcase
        if (lo > hi) return 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 1) ? lo : hi);
        return 16'($urandom_range(hi, lo));
    endfunction

    // Random traffic for one register setting. Frames come in runs that stay
    // in one band, long enough to qualify for a level change most of the time.
    // Some frames carry a fully random value, and now and then a few stray
    // bytes knock the framing out of step.
    task automatic run_random_setting(input int unsigned byte_budget);
        int unsigned start_count;
        int unsigned run_len;
        int          band;
        start_count = bytes_sent;
        while (bytes_sent - start_count < byte_budget) begin
            band    = $urandom_range(0, 3);
            run_len = $urandom_range(1, (sb.qualify > 8'd6) ? 12 : int'(sb.qualify) + 2);
            repeat (run_len) begin
                if (bytes_sent - start_count >= byte_budget) break;
                if ($urandom_range(0, 19) == 0)
                    repeat ($urandom_range(1, 3)) send_rx_byte(8'($urandom));
                if ($urandom_range(0, 9) == 0)
                    send_frame(16'($urandom));
                else
                    send_frame(pick_ppm(band));
            end
        end
    endtask

    // Chooses the next register setting. The first few are the extremes; after
    // that a mix of reset values, ordered, unordered and tight thresholds, and
    // a qualify count of zero.
    task automatic next_setting();
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic [15:0] t;
        a = 16'($urandom);
        b = 16'($urandom);
        c = 16'($urandom);
        // Sort so that a >= b >= c for the ordered styles.
        if (a < b) begin t = a; a = b; b = t; end
        if (b < c) begin t = b; b = c; c = t; end
        if (a < b) begin t = a; a = b; b = t; end
        case ((setting_no < 3) ? setting_no : 3 + $urandom_range(0, 4))
            0: program_monitor(16'hFFFF, 16'h0000, 16'h0000, 8'd1);
            1: program_monitor(16'h0000, 16'h0000, 16'hFFFF, 8'd255);
            2: program_monitor(16'h0000, 16'hFFFF, 16'hFFFF, 8'd2);
            3: program_monitor(RST_HIGH_THR, RST_MID_THR, RST_LOW_THR, RST_QUALIFY);
            4: program_monitor(a, b, c, 8'($urandom_range(1, 6)));
            5: program_monitor(16'($urandom), 16'($urandom), 16'($urandom),
                               8'($urandom_range(1, 4)));
            6: begin
                c = 16'($urandom_range(0, 60000));
                b = c + 16'($urandom_range(0, 200));
                a = b + 16'($urandom_range(0, 200));
                program_monitor(a, b, c, 8'($urandom_range(1, 3)));
            end
            default: program_monitor(a, b, c, 8'd0);
        endcase
        setting_no++;
    endtask

    initial begin
        sb            = new();
        src_idle_pct  = 18;
        sink_idle_pct = 67;
        bytes_sent    = 0;
        tx_pos        = 0;
        setting_no    = 0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_HIGH_THR;
        i_cfg_wdata   <= '0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. With the reset thresholds a full-scale frame only
        // counts up, and a zero frame at the ok level does nothing.
        send_frame(16'hFFFF);
        send_frame(16'h0000);

        // With a qualify count of one, the up counter left at one by the full-scale
        // frame and the down counter still at ten are both stranded, so no frame here
        // moves the level. The frames, boundaries included, aim at ok to error, error to
        // warning, no change in the gap, warning to ok, ok to warning, and error again.
        drain_readings();
        program_monitor(RST_HIGH_THR, RST_MID_THR, RST_LOW_THR, 8'd1);
        send_frame(16'd1001);
        send_frame(16'd1000);
        send_frame(16'd750);
        send_frame(16'd749);
        send_frame(16'd851);
        send_frame(16'd65535);

        // Three middle frames at the ok level bring the up counter, left at one, to four
        // of four, so the level rises to warning and both counters clear; once the count
        // drops to two, middle frames at the warning level move no counter.
        drain_readings();
        program_monitor(RST_HIGH_THR, RST_MID_THR, RST_LOW_THR, 8'd4);
        repeat (3) send_frame(16'd900);
        drain_readings();
        program_monitor(RST_HIGH_THR, RST_MID_THR, RST_LOW_THR, 8'd2);
        repeat (2) send_frame(16'd900);

        // A qualify count of zero freezes the alarm entirely.
        drain_readings();
        program_monitor(RST_HIGH_THR, RST_MID_THR, RST_LOW_THR, 8'd0);
        send_frame(16'd2000);
        send_frame(16'd900);
        send_frame(16'd100);

        // Random part, in three idle patterns: a slow receiver, then a slow
        // sender, then full speed on both sides.
        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct  = (phase == 0) ? 18 : (phase == 1) ? 67 : 0;
            sink_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 18 : 0;
            for (int s = 0; s < 4; s++) begin
                drain_readings();
                next_setting();
                if (phase == 1 && s == 1) begin
                    // Hold the sender mid-setting until every reading is back.
                    run_random_setting(56);
                    drain_readings();
                    run_random_setting(56);
                end else begin
                    run_random_setting(112);
                end
            end
        end

        drain_readings();
        if (sb.mismatches == 0 && sb.pending_readings.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
